[design/tfno_pkg.sv]
// Package for the flat face normal block: beat types, carry record, widths.
// No dependencies; used by tfno_isqrt, tfno_div and triangle_flat_normal_orient.
package tfno_pkg;

  // Input beat: one triangle, three signed Q3.12 vertices
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] bz;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
  } tri_in_t;

  // Output beat: one vertex with the shared normal
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               last_of_triangle;
  } vtx_out_t;

  localparam int MagW = 30;   // normalized magnitude, top one in [2^29, 2^30)
  localparam int SumW = 62;   // sum of three squared magnitudes
  localparam int LenW = 31;   // floor square root of the sum
  localparam int NumW = 45;   // mag * 2^14 + len / 2
  localparam int QW   = 15;   // quotient bits
  localparam logic [QW-1:0] OneQ14 = 15'd16384;

  // Per-item record carried alongside the arithmetic
  typedef struct packed {
    logic [0:8][15:0]      pos;   // scaled a, b, c coordinates
    logic [2:0]            neg;   // cross product component signs
    logic                  zero;  // zero-length cross product
    logic                  flip;  // normal faces the origin
    logic [2:0][MagW-1:0]  mag;   // normalized magnitudes
  } carry_t;

endpackage

[design/tfno_isqrt.sv]
// Pipelined floor square root, one result bit per stage.
// Depends on tfno_pkg for widths and the carry record.
module tfno_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [tfno_pkg::SumW-1:0]     in_sum,
  input  tfno_pkg::carry_t              in_carry,
  output logic                          out_vld,
  output logic [tfno_pkg::LenW-1:0]     out_len,
  output tfno_pkg::carry_t              out_carry
);

  localparam int Steps = 32;

  logic [63:0]      rem_r   [0:Steps];
  logic [63:0]      root_r  [0:Steps];
  tfno_pkg::carry_t carry_r [0:Steps];
  logic [Steps:0]   vld_r;

  // Entry stage: load the radicand
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]   <= {{(64-tfno_pkg::SumW){1'b0}}, in_sum};
      root_r[0]  <= 64'd0;
      carry_r[0] <= in_carry;
    end
  end

  // One restoring step per stage, trial bit from 2^62 down to 2^0
  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Sh = 62 - 2 * k;
    logic [63:0] trial;
    assign trial = root_r[k] + (64'd1 << Sh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        carry_r[k+1] <= carry_r[k];
        if (rem_r[k] >= trial) begin
          rem_r[k+1]  <= rem_r[k] - trial;
          root_r[k+1] <= (root_r[k] >> 1) + (64'd1 << Sh);
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= root_r[k] >> 1;
        end
      end
    end
  end

  assign out_vld   = vld_r[Steps];
  assign out_len   = root_r[Steps][tfno_pkg::LenW-1:0];
  assign out_carry = carry_r[Steps];

endmodule

[design/tfno_div.sv]
// Pipelined restoring divider, three lanes sharing one divisor.
// Depends on tfno_pkg for widths and the carry record.
module tfno_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic [2:0][tfno_pkg::NumW-1:0]       in_num,
  input  logic [tfno_pkg::LenW-1:0]            in_den,
  input  tfno_pkg::carry_t                     in_carry,
  output logic                                 out_vld,
  output logic [2:0][tfno_pkg::QW-1:0]         out_quo,
  output tfno_pkg::carry_t                     out_carry
);

  localparam int Steps = tfno_pkg::QW;

  logic [2:0][tfno_pkg::NumW-1:0] rem_r   [0:Steps];
  logic [2:0][tfno_pkg::QW-1:0]   quo_r   [0:Steps];
  logic [tfno_pkg::LenW-1:0]      den_r   [0:Steps];
  tfno_pkg::carry_t               carry_r [0:Steps];
  logic [Steps:0]                 vld_r;

  // Entry stage: load numerators and divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]   <= in_num;
      quo_r[0]   <= '0;
      den_r[0]   <= in_den;
      carry_r[0] <= in_carry;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Sh = Steps - 1 - k;
    logic [tfno_pkg::NumW:0] dsh;
    assign dsh = {{(tfno_pkg::NumW + 1 - tfno_pkg::LenW){1'b0}}, den_r[k]} << Sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k+1]   <= den_r[k];
        carry_r[k+1] <= carry_r[k];
        for (int l = 0; l < 3; l++) begin
          if ({1'b0, rem_r[k][l]} >= dsh) begin
            rem_r[k+1][l]     <= rem_r[k][l] - dsh[tfno_pkg::NumW-1:0];
            quo_r[k+1][l]     <= quo_r[k][l] | (tfno_pkg::QW'(1) << Sh);
          end else begin
            rem_r[k+1][l]     <= rem_r[k][l];
            quo_r[k+1][l]     <= quo_r[k][l];
          end
        end
      end
    end
  end

  assign out_vld   = vld_r[Steps];
  assign out_quo   = quo_r[Steps];
  assign out_carry = carry_r[Steps];

endmodule

[design/triangle_flat_normal_orient.sv]
// Each triangle leaves as three vertex beats on the one result port; the next is loaded only with the last beat.
// The 58-stage arithmetic pipeline takes a triangle every cycle while it can advance.
// Reset (synchronous, rst_n low) clears all valid bits and sets the scale to 1.0.
// Depends on tfno_pkg, tfno_isqrt and tfno_div.
module triangle_flat_normal_orient (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tfno_pkg::tri_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tfno_pkg::vtx_out_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  logic [15:0] sf_r;
  logic        adv;

  // Scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r <= 16'd4096;
    end else if (cfg_we) begin
      sf_r <= cfg_wdata;
    end
  end

  // Stage 1: scale, floor shift, saturate
  logic [0:8][15:0]   raw;
  logic signed [32:0] prod [0:8];
  logic signed [32:0] shf  [0:8];
  logic [15:0]        sat  [0:8];
  logic [0:8][15:0]   pos1_r;
  logic               vld1_r;

  assign raw = in_data;

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      prod[j] = $signed(raw[j]) * $signed({1'b0, sf_r});
      shf[j]  = prod[j] >>> 12;
      if (shf[j] > 33'sd32767) begin
        sat[j] = 16'h7fff;
      end else if (shf[j] < -33'sd32768) begin
        sat[j] = 16'h8000;
      end else begin
        sat[j] = shf[j][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) pos1_r[j] <= sat[j];
    end
  end

  // Stage 2: edges and vertex sum
  logic signed [16:0] e1_r [0:2];
  logic signed [16:0] e2_r [0:2];
  logic signed [17:0] s2_r [0:2];
  logic [0:8][15:0]   pos2_r;
  logic               vld2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos2_r <= pos1_r;
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= 17'($signed(pos1_r[3+i])) - 17'($signed(pos1_r[i]));
        e2_r[i] <= 17'($signed(pos1_r[6+i])) - 17'($signed(pos1_r[i]));
        s2_r[i] <= 18'($signed(pos1_r[i])) + 18'($signed(pos1_r[3+i]))
                 + 18'($signed(pos1_r[6+i]));
      end
    end
  end

  // Stage 3: cross product partial products
  logic signed [33:0] m3_r [0:5];
  logic signed [17:0] s3_r [0:2];
  logic [0:8][15:0]   pos3_r;
  logic               vld3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos3_r  <= pos2_r;
      s3_r    <= s2_r;
      m3_r[0] <= 34'(e1_r[1]) * 34'(e2_r[2]);
      m3_r[1] <= 34'(e1_r[2]) * 34'(e2_r[1]);
      m3_r[2] <= 34'(e1_r[2]) * 34'(e2_r[0]);
      m3_r[3] <= 34'(e1_r[0]) * 34'(e2_r[2]);
      m3_r[4] <= 34'(e1_r[0]) * 34'(e2_r[1]);
      m3_r[5] <= 34'(e1_r[1]) * 34'(e2_r[0]);
    end
  end

  // Stage 4: cross product
  logic signed [34:0] cr4_r [0:2];
  logic signed [17:0] s4_r  [0:2];
  logic [0:8][15:0]   pos4_r;
  logic               vld4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos4_r <= pos3_r;
      s4_r   <= s3_r;
      for (int i = 0; i < 3; i++) begin
        cr4_r[i] <= 35'(m3_r[2*i]) - 35'(m3_r[2*i+1]);
      end
    end
  end

  // Stage 5: magnitudes, largest one, dot product terms
  logic [33:0]        mag5_r [0:2];
  logic [33:0]        mx5_r;
  logic [2:0]         neg5_r;
  logic signed [52:0] dp5_r  [0:2];
  logic [0:8][15:0]   pos5_r;
  logic               vld5_r;
  logic [34:0]        abs4   [0:2];
  logic [33:0]        mx4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs4[i] = cr4_r[i][34] ? 35'(-cr4_r[i]) : 35'(cr4_r[i]);
    end
    mx4 = abs4[0][33:0];
    if (abs4[1][33:0] > mx4) mx4 = abs4[1][33:0];
    if (abs4[2][33:0] > mx4) mx4 = abs4[2][33:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos5_r <= pos4_r;
      mx5_r  <= mx4;
      for (int i = 0; i < 3; i++) begin
        mag5_r[i] <= abs4[i][33:0];
        neg5_r[i] <= cr4_r[i][34];
        dp5_r[i]  <= 53'(cr4_r[i]) * 53'(s4_r[i]);
      end
    end
  end

  // Stage 6: leading zero count, degenerate check, orientation
  logic [33:0]        mag6_r [0:2];
  logic [5:0]         lz6_r;
  logic               zero6_r;
  logic               flip6_r;
  logic [2:0]         neg6_r;
  logic [0:8][15:0]   pos6_r;
  logic               vld6_r;
  logic [5:0]         lz5;
  logic signed [54:0] dot5;

  always_comb begin
    lz5 = 6'd0;
    for (int b = 0; b < 34; b++) begin
      if (mx5_r[b]) lz5 = 6'(33 - b);
    end
    dot5 = 55'(dp5_r[0]) + 55'(dp5_r[1]) + 55'(dp5_r[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos6_r  <= pos5_r;
      mag6_r  <= mag5_r;
      neg6_r  <= neg5_r;
      lz6_r   <= lz5;
      zero6_r <= (mx5_r == 34'd0);
      flip6_r <= dot5[54];
    end
  end

  // Stage 7: normalizing shift, build the carry record
  tfno_pkg::carry_t car7_r;
  logic             vld7_r;
  logic [33:0]      shl6 [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) shl6[i] = mag6_r[i] << lz6_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      car7_r.pos  <= pos6_r;
      car7_r.neg  <= neg6_r;
      car7_r.zero <= zero6_r;
      car7_r.flip <= flip6_r;
      for (int i = 0; i < 3; i++) car7_r.mag[i] <= shl6[i][33:4];
    end
  end

  // Stage 8: squares
  logic [59:0]      sq8_r [0:2];
  tfno_pkg::carry_t car8_r;
  logic             vld8_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      car8_r <= car7_r;
      for (int i = 0; i < 3; i++) begin
        sq8_r[i] <= 60'(car7_r.mag[i]) * 60'(car7_r.mag[i]);
      end
    end
  end

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
      vld8_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
      vld8_r <= vld7_r;
    end
  end

  // Square root of the summed squares
  logic [tfno_pkg::SumW-1:0] sum8;
  logic                      sq_vld;
  logic [tfno_pkg::LenW-1:0] sq_len;
  tfno_pkg::carry_t          sq_car;

  assign sum8 = tfno_pkg::SumW'(sq8_r[0]) + tfno_pkg::SumW'(sq8_r[1])
              + tfno_pkg::SumW'(sq8_r[2]);

  tfno_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_vld    (vld8_r),
    .in_sum    (sum8),
    .in_carry  (car8_r),
    .out_vld   (sq_vld),
    .out_len   (sq_len),
    .out_carry (sq_car)
  );

  // Divider setup: rounded numerators
  logic [2:0][tfno_pkg::NumW-1:0] num_r;
  logic [tfno_pkg::LenW-1:0]      den_r;
  tfno_pkg::carry_t               carp_r;
  logic                           vldp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldp_r <= 1'b0;
    end else if (adv) begin
      vldp_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r  <= sq_len;
      carp_r <= sq_car;
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= {1'b0, sq_car.mag[i], 14'd0}
                  + tfno_pkg::NumW'(sq_len >> 1);
      end
    end
  end

  logic                         dv_vld;
  logic [2:0][tfno_pkg::QW-1:0] dv_quo;
  tfno_pkg::carry_t             dv_car;

  tfno_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_vld    (vldp_r),
    .in_num    (num_r),
    .in_den    (den_r),
    .in_carry  (carp_r),
    .out_vld   (dv_vld),
    .out_quo   (dv_quo),
    .out_carry (dv_car)
  );

  // Output stage: three vertex beats per triangle
  tfno_pkg::vtx_out_t vtx_r [0:2];
  logic               busy_r;
  logic [1:0]         cnt_r;
  logic               out_fire;
  logic               load_ok;
  logic [15:0]        nrm [0:2];
  logic [tfno_pkg::QW-1:0] qc [0:2];
  logic [0:8][15:0]   vp;

  assign out_fire = busy_r && !out_stall;
  assign load_ok  = !busy_r || (out_fire && cnt_r == 2'd2);
  assign adv      = !dv_vld || load_ok;
  assign in_stall = !adv;
  assign out_valid = busy_r;

  // Clamp, sign and orient the normal, or zero it for a degenerate triangle; order the vertices
  always_comb begin
    vp = dv_car.pos;
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_quo[i] > tfno_pkg::OneQ14) ? tfno_pkg::OneQ14 : dv_quo[i];
      if (dv_car.zero) begin
        nrm[i] = 16'd0;
      end else if (dv_car.neg[i] ^ dv_car.flip) begin
        nrm[i] = 16'(-{1'b0, qc[i]});
      end else begin
        nrm[i] = {1'b0, qc[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dv_vld && load_ok) begin
      for (int k = 0; k < 3; k++) begin
        vtx_r[k].norm_x <= nrm[0];
        vtx_r[k].norm_y <= nrm[1];
        vtx_r[k].norm_z <= nrm[2];
        vtx_r[k].last_of_triangle <= (k == 2);
      end
      vtx_r[0].pos_x <= vp[0];
      vtx_r[0].pos_y <= vp[1];
      vtx_r[0].pos_z <= vp[2];
      vtx_r[1].pos_x <= dv_car.flip ? vp[6] : vp[3];
      vtx_r[1].pos_y <= dv_car.flip ? vp[7] : vp[4];
      vtx_r[1].pos_z <= dv_car.flip ? vp[8] : vp[5];
      vtx_r[2].pos_x <= dv_car.flip ? vp[3] : vp[6];
      vtx_r[2].pos_y <= dv_car.flip ? vp[4] : vp[7];
      vtx_r[2].pos_z <= dv_car.flip ? vp[5] : vp[8];
    end
  end

  // Advance the beat counter; reload when idle or on the last beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (dv_vld && load_ok) begin
      busy_r <= 1'b1;
      cnt_r  <= 2'd0;
    end else if (out_fire) begin
      if (cnt_r == 2'd2) begin
        busy_r <= 1'b0;
        cnt_r  <= 2'd0;
      end else begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_comb begin
    unique case (cnt_r)
      2'd0:    out_data = vtx_r[0];
      2'd1:    out_data = vtx_r[1];
      default: out_data = vtx_r[2];
    endcase
  end

`ifndef ASSERT_OFF
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.norm_x >= -16'sd16384 && out_data.norm_x <= 16'sd16384
               && out_data.norm_y >= -16'sd16384 && out_data.norm_y <= 16'sd16384
               && out_data.norm_z >= -16'sd16384 && out_data.norm_z <= 16'sd16384)
    else $error("normal component out of range");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 2'd3)
    else $error("beat counter out of range");

  a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld && load_ok) |=> (out_valid && cnt_r == 2'd0 && !out_data.last_of_triangle))
    else $error("new triangle does not start at its first vertex");
`endif

endmodule
